/* sv/grwf_pkg.sv */
package grwf_pkg;

   localparam logic [17:0] DIST_CAP = 18'h3FFFF;

   // divider chain widths
   localparam int NUM_W = 27;
   localparam int DEN_W = 15;
   localparam int REM_W = 15;

   localparam logic CMD_CAST = 1'b0;
   localparam logic CMD_ROW  = 1'b1;

   localparam logic [1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [1:0] CSR_MAP_W    = 2'd1;
   localparam logic [1:0] CSR_MAP_H    = 2'd2;

   localparam logic [1:0] FACE_WEST  = 2'd0;
   localparam logic [1:0] FACE_NORTH = 2'd1;
   localparam logic [1:0] FACE_EAST  = 2'd2;
   localparam logic [1:0] FACE_SOUTH = 2'd3;

   localparam logic [1:0] STOP_WALL = 2'd0;
   localparam logic [1:0] STOP_OFF  = 2'd1;
   localparam logic [1:0] STOP_END  = 2'd2;
   localparam logic [1:0] STOP_MAX  = 2'd3;

   localparam logic [1:0] TAG_PX = 2'd0;
   localparam logic [1:0] TAG_PY = 2'd1;
   localparam logic [1:0] TAG_SX = 2'd2;
   localparam logic [1:0] TAG_SY = 2'd3;

   typedef struct packed {
      logic        command;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [11:0] ray_angle;
      logic [3:0]  row_index;
      logic [15:0] row_cells;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [17:0] distance;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic [3:0]  cell_x;
      logic [3:0]  cell_y;
      logic [1:0]  face;
      logic [1:0]  stop_reason;
   } rsp_type;

   typedef struct packed {
      logic             vld;
      logic [1:0]       tag;
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } div_beat_type;

   localparam logic [14:0] SINE_TAB [33] = '{
      15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756, 15'd5520,
      15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760, 15'd10394,
      15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623,
      15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426, 15'd15679,
      15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364, 15'd16384
   };

   // Q1.14 sine of a 16-bit phase, quarter table with linear interpolation
   function automatic logic signed [15:0] sine_q14(input logic [15:0] phase);
      logic [14:0] r;
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [14:0] lo;
      logic [14:0] diff;
      logic [23:0] prod;
      logic [14:0] v;
      r = {1'b0, phase[13:0]};
      if (phase[14]) begin
         r = 15'd16384 - r;
      end
      idx  = r[14:9];
      frac = r[8:0];
      lo   = SINE_TAB[idx];
      if (idx >= 6'd32) begin
         v = 15'd16384;
      end else begin
         diff = SINE_TAB[idx + 6'd1] - lo;
         prod = {9'd0, diff} * {15'd0, frac};
         v    = lo + prod[23:9];
      end
      return phase[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

endpackage

/* sv/grwf_div_cell.sv */
module grwf_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  grwf_pkg::div_beat_type beat_in,
   output grwf_pkg::div_beat_type beat_out
);

   logic [grwf_pkg::REM_W:0] trial;
   logic [grwf_pkg::REM_W:0] diff;
   logic                     ge;
   logic                     vld_ff;
   grwf_pkg::div_beat_type   pay_ff;
   grwf_pkg::div_beat_type   pay_in;

   // one restoring step: bring down the next numerator bit
   always_comb begin
      trial = {beat_in.rem, beat_in.num[grwf_pkg::NUM_W-1]};
      diff  = trial - {1'b0, beat_in.den};
      ge    = trial >= {1'b0, beat_in.den};
      pay_in     = beat_in;
      pay_in.rem = ge ? diff[grwf_pkg::REM_W-1:0] : trial[grwf_pkg::REM_W-1:0];
      pay_in.num = {beat_in.num[grwf_pkg::NUM_W-2:0], 1'b0};
      pay_in.quo = {beat_in.quo[grwf_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= beat_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff <= pay_in;
   end

   always_comb begin
      beat_out     = pay_ff;
      beat_out.vld = vld_ff;
   end

endmodule

/* sv/grwf_div_chain.sv */
module grwf_div_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  grwf_pkg::div_beat_type beat_in,
   output grwf_pkg::div_beat_type beat_out
);

   grwf_pkg::div_beat_type stage_w [grwf_pkg::NUM_W+1];

   assign stage_w[0] = beat_in;

   // one quotient bit per cell, MSB first
   for (genvar k = 0; k < grwf_pkg::NUM_W; k++) begin : g_cell
      grwf_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .beat_in  (stage_w[k]),
         .beat_out (stage_w[k+1])
      );
   end

   assign beat_out = stage_w[grwf_pkg::NUM_W];

endmodule

/* sv/grid_ray_wall_finder_top.sv */
// Grid ray wall finder. A beat on req_ either writes one row of the wall map
// (command 1) or casts a ray (command 0) from a Q4.12 origin at a binary angle
// and walks the map cell by cell (DDA) until it meets a wall, leaves the map,
// reaches the end cell of the ray or passes max_distance. Every request gives
// exactly one rsp_ beat; a row write answers with all zero. One request is
// worked at a time; a new one is taken while the previous answer still waits
// in the output register. A cast first runs a setup (direction lookup, four
// divisions by the direction components streamed through a 27-cell restoring
// divider chain, end cell products), then visits cells, each with a registered
// map row read and then a test and step; on a wall hit it forms the hit point
// with the shared multiplier, and last it loads the output register once free.
// The map resets to all open through one valid bit per row. Config writes
// are always taken (csr_ready is high) and belong to idle periods.
module grid_ray_wall_finder_top #(
   parameter int MAP_DIM    = 16,
   parameter int ANGLE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grwf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grwf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [17:0]       csr_data
);

   localparam int          RW       = $clog2(MAP_DIM);
   localparam int          PH_SH    = 16 - ANGLE_BITS;
   localparam logic [15:0] ANG_MASK = 16'((32'd1 << ANGLE_BITS) - 32'd1);
   localparam logic [6:0]  DIM7     = 7'(MAP_DIM);

   typedef enum logic [3:0] {
      S_IDLE, S_SINE, S_FEED, S_WAIT, S_READ, S_EVAL, S_HIT0, S_HIT1, S_HIT2, S_OUT
   } state_type;

   state_type state_ff;

   // config
   logic [17:0] max_dist_ff;
   logic [4:0]  map_w_ff;
   logic [4:0]  map_h_ff;
   logic [6:0]  w_eff;
   logic [6:0]  h_eff;

   // ray set-up
   logic [15:0]        ox_ff;
   logic [15:0]        oy_ff;
   logic [15:0]        phase_ff;
   logic [15:0]        ang_m;
   logic signed [15:0] dx_ff;
   logic signed [15:0] dy_ff;
   logic               dx_pos;
   logic               dy_pos;
   logic [1:0]         cnt_ff;

   // shared multiplier
   logic signed [18:0] mul_a;
   logic signed [15:0] mul_b;
   logic signed [34:0] prod_ff;
   logic [15:0]        org;
   logic signed [35:0] end_sum;
   logic signed [35:0] hit_sum;
   logic signed [35:0] hit_v;
   logic [15:0]        hit_clamp;
   logic signed [9:0]  endx_ff;
   logic signed [9:0]  endy_ff;

   // divider
   grwf_pkg::div_beat_type div_in;
   grwf_pkg::div_beat_type div_out;
   logic [12:0]            frac_x;
   logic [12:0]            frac_y;
   logic [17:0]            quo_sat;

   // walk
   logic [17:0]       px_ff;
   logic [17:0]       py_ff;
   logic [17:0]       sx_ff;
   logic [17:0]       sy_ff;
   logic [18:0]       px_sum;
   logic [18:0]       py_sum;
   logic [17:0]       dist_ff;
   logic signed [7:0] cx_ff;
   logic signed [7:0] cy_ff;
   logic [1:0]        face_ff;
   logic [1:0]        reason_ff;
   logic              wall_ff;
   logic [15:0]       hitx_ff;
   logic [15:0]       hity_ff;
   logic              off_c;
   logic              wall_c;
   logic              end_c;
   logic              addr_ok;

   // map store
   logic [MAP_DIM-1:0] map_mem [MAP_DIM];
   logic [MAP_DIM-1:0] row_vld_ff;
   logic [MAP_DIM-1:0] rd_row_ff;
   logic               rd_vld_ff;
   logic [MAP_DIM-1:0] row_data;
   logic [6:0]         row7;
   logic               row_ok;
   logic               row_wr;

   grwf_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_load;
   logic              req_acc;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // sizes above the store clamp to it
   assign w_eff = ({2'b0, map_w_ff} > DIM7) ? DIM7 : {2'b0, map_w_ff};
   assign h_eff = ({2'b0, map_h_ff} > DIM7) ? DIM7 : {2'b0, map_h_ff};

   assign ang_m  = {4'b0, req_data.ray_angle} & ANG_MASK;
   assign dx_pos = !dx_ff[15] && (dx_ff != 16'sd0);
   assign dy_pos = !dy_ff[15] && (dy_ff != 16'sd0);

   // distance to the next border in the direction of travel
   assign frac_x = dx_pos ? (13'd4096 - {1'b0, ox_ff[11:0]}) : {1'b0, ox_ff[11:0]};
   assign frac_y = dy_pos ? (13'd4096 - {1'b0, oy_ff[11:0]}) : {1'b0, oy_ff[11:0]};

   always_comb begin
      div_in     = '0;
      div_in.vld = (state_ff == S_FEED);
      div_in.tag = cnt_ff;
      case (cnt_ff)
         grwf_pkg::TAG_PX: div_in.num = {frac_x, 14'd0};
         grwf_pkg::TAG_PY: div_in.num = {frac_y, 14'd0};
         default:          div_in.num = 27'd1 << 26;
      endcase
      if (cnt_ff == grwf_pkg::TAG_PX || cnt_ff == grwf_pkg::TAG_SX) begin
         div_in.den = dx_ff[15] ? 15'(-dx_ff) : dx_ff[14:0];
      end else begin
         div_in.den = dy_ff[15] ? 15'(-dy_ff) : dy_ff[14:0];
      end
   end

   grwf_div_chain u_div (
      .clock    (clock),
      .reset    (reset),
      .beat_in  (div_in),
      .beat_out (div_out)
   );

   // zero component or overflow saturates
   assign quo_sat = (div_out.den == '0 || div_out.quo[26:18] != '0) ?
                    grwf_pkg::DIST_CAP : div_out.quo[17:0];

   // multiplier operands: max_distance during set-up, distance at the hit
   always_comb begin
      mul_a = (state_ff == S_FEED) ? $signed({1'b0, max_dist_ff}) : $signed({1'b0, dist_ff});
      mul_b = ((state_ff == S_FEED && cnt_ff == 2'd0) || state_ff == S_HIT0) ? dx_ff : dy_ff;
      org   = ((state_ff == S_FEED && cnt_ff == 2'd1) || state_ff == S_HIT1) ? ox_ff : oy_ff;
   end

   // end cell: floor((o << 14 + maxd * c) / 2^26)
   assign end_sum = $signed({6'b0, org, 14'd0}) + 36'(prod_ff);
   // hit point: o + floor((dist * c + 8192) / 2^14), clamped
   assign hit_sum = 36'(prod_ff) + 36'sd8192;
   assign hit_v   = (hit_sum >>> 14) + $signed({20'b0, org});
   always_comb begin
      if (hit_v < 36'sd0) begin
         hit_clamp = 16'd0;
      end else if (hit_v > 36'sd65535) begin
         hit_clamp = 16'hFFFF;
      end else begin
         hit_clamp = hit_v[15:0];
      end
   end

   // cell tests on the row read last cycle
   assign off_c  = cx_ff[7] || cy_ff[7] || (cx_ff[6:0] >= w_eff) || (cy_ff[6:0] >= h_eff);
   assign wall_c = !off_c && rd_vld_ff && rd_row_ff[cx_ff[RW-1:0]];
   assign end_c  = ({{2{cx_ff[7]}}, cx_ff} == endx_ff) && ({{2{cy_ff[7]}}, cy_ff} == endy_ff);
   assign addr_ok = !cy_ff[7] && (cy_ff[6:0] < DIM7);
   assign px_sum  = {1'b0, px_ff} + {1'b0, sx_ff};
   assign py_sum  = {1'b0, py_ff} + {1'b0, sy_ff};

   // row write; columns past 16 stay open
   assign row7   = {3'b0, req_data.row_index};
   assign row_ok = row7 < DIM7;
   assign row_wr = req_acc && (req_data.command == grwf_pkg::CMD_ROW) && row_ok;
   always_comb begin
      for (int j = 0; j < MAP_DIM; j++) begin
         row_data[j] = (j < 16) ? req_data.row_cells[j % 16] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (row_wr) begin
         map_mem[row7[RW-1:0]] <= row_data;
      end
      rd_row_ff <= map_mem[cy_ff[RW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (row_wr) begin
            row_vld_ff[row7[RW-1:0]] <= 1'b1;
         end
         rd_vld_ff <= addr_ok && row_vld_ff[cy_ff[RW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= 18'd102400;
         map_w_ff    <= 5'd16;
         map_h_ff    <= 5'd16;
      end else if (csr_valid) begin
         case (csr_index)
            grwf_pkg::CSR_MAX_DIST: max_dist_ff <= csr_data;
            grwf_pkg::CSR_MAP_W:    map_w_ff    <= csr_data[4:0];
            grwf_pkg::CSR_MAP_H:    map_h_ff    <= csr_data[4:0];
            default:                ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            ox_ff    <= req_data.origin_x;
            oy_ff    <= req_data.origin_y;
            phase_ff <= ang_m << PH_SH;
            cx_ff    <= {4'b0, req_data.origin_x[15:12]};
            cy_ff    <= {4'b0, req_data.origin_y[15:12]};
            dist_ff  <= '0;
            face_ff  <= grwf_pkg::FACE_WEST;
            wall_ff  <= 1'b0;
            reason_ff <= grwf_pkg::STOP_WALL;
         end
         S_SINE: begin
            dx_ff <= grwf_pkg::sine_q14(phase_ff + 16'h4000);
            dy_ff <= grwf_pkg::sine_q14(phase_ff);
         end
         S_FEED: begin
            if (cnt_ff == 2'd1) begin
               endx_ff <= 10'(end_sum >>> 26);
            end
            if (cnt_ff == 2'd2) begin
               endy_ff <= 10'(end_sum >>> 26);
            end
         end
         S_EVAL: begin
            if (off_c || wall_c || end_c || dist_ff >= max_dist_ff) begin
               wall_ff   <= wall_c;
               reason_ff <= wall_c ? grwf_pkg::STOP_WALL :
                            off_c  ? grwf_pkg::STOP_OFF  :
                            end_c  ? grwf_pkg::STOP_END  : grwf_pkg::STOP_MAX;
            end else if (px_ff < py_ff) begin
               cx_ff   <= dx_pos ? cx_ff + 8'sd1 : cx_ff - 8'sd1;
               dist_ff <= px_ff;
               px_ff   <= px_sum[18] ? grwf_pkg::DIST_CAP : px_sum[17:0];
               face_ff <= dx_pos ? grwf_pkg::FACE_WEST : grwf_pkg::FACE_EAST;
            end else begin
               cy_ff   <= dy_pos ? cy_ff + 8'sd1 : cy_ff - 8'sd1;
               dist_ff <= py_ff;
               py_ff   <= py_sum[18] ? grwf_pkg::DIST_CAP : py_sum[17:0];
               face_ff <= dy_pos ? grwf_pkg::FACE_NORTH : grwf_pkg::FACE_SOUTH;
            end
         end
         S_HIT1: hitx_ff <= hit_clamp;
         S_HIT2: hity_ff <= hit_clamp;
         default: ;
      endcase
      if (div_out.vld) begin
         case (div_out.tag)
            grwf_pkg::TAG_PX: px_ff <= quo_sat;
            grwf_pkg::TAG_PY: py_ff <= quo_sat;
            grwf_pkg::TAG_SX: sx_ff <= quo_sat;
            default:          sy_ff <= quo_sat;
         endcase
      end
      if (rsp_load) begin
         rsp_ff.hit         <= wall_ff;
         rsp_ff.distance    <= wall_ff ? dist_ff : '0;
         rsp_ff.hit_x       <= wall_ff ? hitx_ff : '0;
         rsp_ff.hit_y       <= wall_ff ? hity_ff : '0;
         rsp_ff.cell_x      <= wall_ff ? cx_ff[3:0] : '0;
         rsp_ff.cell_y      <= wall_ff ? cy_ff[3:0] : '0;
         rsp_ff.face        <= wall_ff ? face_ff : grwf_pkg::FACE_WEST;
         rsp_ff.stop_reason <= reason_ff;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_acc) begin
                  state_ff <= (req_data.command == grwf_pkg::CMD_ROW) ? S_OUT : S_SINE;
               end
            end
            S_SINE: state_ff <= S_FEED;
            S_FEED: begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == grwf_pkg::TAG_SY) begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (div_out.vld && div_out.tag == grwf_pkg::TAG_SY) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               if (off_c || wall_c || end_c || dist_ff >= max_dist_ff) begin
                  state_ff <= wall_c ? S_HIT0 : S_OUT;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_HIT0: state_ff <= S_HIT1;
            S_HIT1: state_ff <= S_HIT2;
            S_HIT2: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken while a request was in work");

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_out.vld |-> state_ff == S_WAIT)
      else $error("divider beat outside the wait phase");

   a_hit_means_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.hit |-> rsp_ff.stop_reason == grwf_pkg::STOP_WALL)
      else $error("hit reported with a non-wall stop");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("held answer changed");
`endif

endmodule
